// ===== hdl/tpba_pkg.sv =====
// ----------------------------------------------------------------------------
// tpba_pkg
// Shared constants, types and helpers of the two-pool block allocator.
// ----------------------------------------------------------------------------
package tpba_pkg;

  localparam int BLOCKS_PER_POOL = 16;
  localparam int TOTAL_BLOCKS    = 2 * BLOCKS_PER_POOL;
  localparam int BLK_W           = $clog2(TOTAL_BLOCKS);
  localparam int CNT_W           = $clog2(BLOCKS_PER_POOL + 1);

  localparam int SIZE_W      = 8;
  localparam int HANDLE_W    = 6;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADHANDLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SMALL_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_BYTES = 1'b1;

  localparam logic [CFG_W-1:0] SMALL_BYTES_RST = 8'd4;
  localparam logic [CFG_W-1:0] LARGE_BYTES_RST = 8'd8;

  typedef struct packed {
    logic accept;
    logic commit;
  } tpba_cmd_t;

  // Link value of a block that was never written since reset.
  function automatic logic [BLK_W-1:0] reset_link(input logic [BLK_W-1:0] blk);
    logic [BLK_W-1:0] base;
    base = (blk >= BLK_W'(BLOCKS_PER_POOL)) ? BLK_W'(BLOCKS_PER_POOL) : '0;
    if ((blk - base) == BLK_W'(BLOCKS_PER_POOL - 1)) begin
      return base;
    end else begin
      return blk + 1'b1;
    end
  endfunction

endpackage

// ===== hdl/tpba_ram.sv =====
// ----------------------------------------------------------------------------
// tpba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tpba_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpba_ctrl
// Request sequencer: accept a request, commit it, hold the result register.
// ----------------------------------------------------------------------------
module tpba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output tpba_pkg::tpba_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign cmd.accept = in_tvalid && in_tready;
  assign cmd.commit = (state_r == ST_BUSY);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.commit)
    else $error("accepted request not committed next cycle");
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not load the result register");
  a_commit_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !in_tready)
    else $error("input ready during commit");
`endif

endmodule

// ===== hdl/tpba_dp.sv =====
// ----------------------------------------------------------------------------
// tpba_dp
// Allocator datapath: limits, pool heads and counts, link memory, result.
// ----------------------------------------------------------------------------
module tpba_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tpba_pkg::tpba_cmd_t                 cmd,
  input  logic                                cfg_we,
  input  logic [tpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpba_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_kind,
  input  logic [tpba_pkg::SIZE_W-1:0]         in_size,
  input  logic [tpba_pkg::HANDLE_W-1:0]       in_handle,
  output logic [tpba_pkg::OUT_TDATA_W-1:0]    out_data
);

  logic [tpba_pkg::CFG_W-1:0] small_bytes_r, large_bytes_r;
  logic [tpba_pkg::BLK_W-1:0] head0_r, head1_r;
  logic [tpba_pkg::CNT_W-1:0] cnt0_r, cnt1_r;
  logic [tpba_pkg::TOTAL_BLOCKS-1:0] valid_r;

  logic                       op_kind_r, op_ok_r, op_pool_r;
  logic [tpba_pkg::BLK_W-1:0] op_blk_r;
  logic [tpba_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                       fit_s, fit_l, sel_pool, h_bad, h_pool;
  logic [tpba_pkg::BLK_W-1:0] rd_addr, ram_rdata, link_nxt, op_head;
  logic [tpba_pkg::STATUS_W-1:0] res_status;
  logic [tpba_pkg::BLK_W-1:0] res_blk;
  logic                       res_pool, wr_en;

  always_comb begin
    fit_s    = (in_size <= small_bytes_r) && (cnt0_r != '0);
    fit_l    = (in_size <= large_bytes_r) && (cnt1_r != '0);
    sel_pool = !fit_s;
    rd_addr  = sel_pool ? head1_r : head0_r;
    h_bad    = (in_handle >= tpba_pkg::HANDLE_W'(tpba_pkg::TOTAL_BLOCKS));
    h_pool   = (in_handle >= tpba_pkg::HANDLE_W'(tpba_pkg::BLOCKS_PER_POOL));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_kind_r <= in_kind;
      if (in_kind) begin
        op_ok_r   <= !h_bad;
        op_pool_r <= h_pool;
        op_blk_r  <= in_handle[tpba_pkg::BLK_W-1:0];
      end else begin
        op_ok_r   <= fit_s || fit_l;
        op_pool_r <= sel_pool;
        op_blk_r  <= rd_addr;
      end
    end
  end

  assign op_head = op_pool_r ? head1_r : head0_r;
  assign wr_en   = cmd.commit && op_kind_r && op_ok_r;

  tpba_ram #(
    .WIDTH (tpba_pkg::BLK_W),
    .DEPTH (tpba_pkg::TOTAL_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (op_blk_r),
    .wdata (op_head),
    .re    (cmd.accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign link_nxt = valid_r[op_blk_r] ? ram_rdata : tpba_pkg::reset_link(op_blk_r);

  always_comb begin
    res_status = tpba_pkg::ST_OK;
    res_blk    = '0;
    res_pool   = 1'b0;
    if (!op_ok_r) begin
      res_status = op_kind_r ? tpba_pkg::ST_BADHANDLE : tpba_pkg::ST_NOFIT;
    end else begin
      res_pool = op_pool_r;
      if (!op_kind_r) begin
        res_blk = op_blk_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_bytes_r <= tpba_pkg::SMALL_BYTES_RST;
      large_bytes_r <= tpba_pkg::LARGE_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpba_pkg::REG_SMALL_BYTES: small_bytes_r <= cfg_wdata;
        tpba_pkg::REG_LARGE_BYTES: large_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head0_r <= '0;
      head1_r <= tpba_pkg::BLK_W'(tpba_pkg::BLOCKS_PER_POOL);
      cnt0_r  <= tpba_pkg::CNT_W'(tpba_pkg::BLOCKS_PER_POOL);
      cnt1_r  <= tpba_pkg::CNT_W'(tpba_pkg::BLOCKS_PER_POOL);
      valid_r <= '0;
    end else if (cmd.commit && op_ok_r) begin
      if (op_kind_r) begin
        valid_r[op_blk_r] <= 1'b1;
        if (op_pool_r) begin
          head1_r <= op_blk_r;
          if (cnt1_r < tpba_pkg::CNT_W'(tpba_pkg::BLOCKS_PER_POOL)) begin
            cnt1_r <= cnt1_r + 1'b1;
          end
        end else begin
          head0_r <= op_blk_r;
          if (cnt0_r < tpba_pkg::CNT_W'(tpba_pkg::BLOCKS_PER_POOL)) begin
            cnt0_r <= cnt0_r + 1'b1;
          end
        end
      end else begin
        if (op_pool_r) begin
          head1_r <= link_nxt;
          cnt1_r  <= cnt1_r - 1'b1;
        end else begin
          head0_r <= link_nxt;
          cnt0_r  <= cnt0_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {res_pool, res_blk, res_status};
    end
  end

  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_cnt0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt0_r <= tpba_pkg::CNT_W'(tpba_pkg::BLOCKS_PER_POOL))
    else $error("small pool free count above pool size");
  a_cnt1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt1_r <= tpba_pkg::CNT_W'(tpba_pkg::BLOCKS_PER_POOL))
    else $error("large pool free count above pool size");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !op_kind_r && op_ok_r && !op_pool_r)
      |=> (cnt0_r == $past(cnt0_r) - 1'b1))
    else $error("small pool pop did not decrement free count");
`endif

endmodule

// ===== hdl/two_pool_block_allocator.sv =====
// ----------------------------------------------------------------------------
// two_pool_block_allocator
// Fixed-size block allocator over a small and a large pool, each a LIFO
// free list threaded through a shared link RAM.
//
// Input stream: in_tuser selects the request (0 allocate, 1 free); in_tdata
// carries the requested size and the handle to free. Output stream: one
// result per request with status, allocated handle and pool.
// Each request is taken in its transfer cycle, which issues the link RAM
// read of the pool head; the next cycle writes the link of a freed block
// back, updates the head and count and loads the result register. A new
// request is taken in the cycle after that only if the result leaves the
// output in that cycle.
// Reset frees every block, threads each list in index order and sets the
// size limits to 4 and 8 bytes; no clearing pass is needed.
// When the receiver stalls, the result holds and in_tready stays low.
// The user must write size limits on the cfg port only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module two_pool_block_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpba_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tpba_pkg::IN_TDATA_W-1:0]     in_tdata,  // req_size, free_handle, zero pad
  input  logic                                in_tuser,  // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tpba_pkg::OUT_TDATA_W-1:0]    out_tdata  // status, alloc_handle, alloc_pool
);

  tpba_pkg::tpba_cmd_t cmd;

  tpba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tpba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_kind   (in_tuser),
    .in_size   (in_tdata[tpba_pkg::SIZE_W-1:0]),
    .in_handle (in_tdata[tpba_pkg::SIZE_W +: tpba_pkg::HANDLE_W]),
    .out_data  (out_tdata)
  );

endmodule

// ===== tb/two_pool_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// two_pool_block_allocator_tb
// Self-checking bench for the two-pool block allocator.
//
// A directed table covers reset state, size extremes, bad handles, double
// frees, draining the small pool and the fallback to the large pool. Random
// traffic follows under eight size-limit settings and four flow-control
// mixes. Every result is checked field by field against the expected value in
// the table or against an in-bench model of both free lists.
// ----------------------------------------------------------------------------
module two_pool_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpba_pkg::*;

  localparam bit KIND_ALLOC = 1'b0;
  localparam bit KIND_FREE  = 1'b1;
  localparam bit POOL_SMALL = 1'b0;
  localparam bit POOL_LARGE = 1'b1;
  localparam int N_DIR      = 17;
  localparam int N_PHASES   = 8;
  localparam int PHASE_REQS = 50;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    handle;
    logic                pool;
  } alloc_result_t;

  typedef struct packed {
    logic                kind;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] hdl;
    logic [4:0]          rep;
    logic                typed;
    alloc_result_t       res;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // req_size, free_handle, zero pad
  logic                   in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // status, alloc_handle, alloc_pool

  two_pool_block_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // free-list model
  logic [BLK_W-1:0] link_mem [TOTAL_BLOCKS];
  logic [BLK_W-1:0] head [2];
  logic [CNT_W-1:0] free_cnt [2];
  logic [CFG_W-1:0] size_limit [2];

  alloc_result_t    pending_results [$];
  logic [BLK_W-1:0] live_blocks [$];

  int gap_pct;
  int stall_pct;
  int errors;
  int n_reqs, n_ok_alloc, n_fallback, n_nofit, n_badhandle, n_frees;

  dir_row_t dir_tab [N_DIR] = '{
    '{KIND_ALLOC, 8'd0,   6'd0,  5'd1,  1'b1, '{ST_OK,        5'd0,  POOL_SMALL}},
    '{KIND_ALLOC, 8'd4,   6'd0,  5'd1,  1'b1, '{ST_OK,        5'd1,  POOL_SMALL}},
    '{KIND_ALLOC, 8'd5,   6'd0,  5'd1,  1'b1, '{ST_OK,        5'd16, POOL_LARGE}},
    '{KIND_ALLOC, 8'd8,   6'd0,  5'd1,  1'b1, '{ST_OK,        5'd17, POOL_LARGE}},
    '{KIND_ALLOC, 8'd9,   6'd0,  5'd1,  1'b1, '{ST_NOFIT,     5'd0,  POOL_SMALL}},
    '{KIND_ALLOC, 8'd255, 6'd63, 5'd1,  1'b1, '{ST_NOFIT,     5'd0,  POOL_SMALL}},
    '{KIND_FREE,  8'd255, 6'd63, 5'd1,  1'b1, '{ST_BADHANDLE, 5'd0,  POOL_SMALL}},
    '{KIND_FREE,  8'd0,   6'd32, 5'd1,  1'b1, '{ST_BADHANDLE, 5'd0,  POOL_SMALL}},
    '{KIND_FREE,  8'd0,   6'd0,  5'd1,  1'b1, '{ST_OK,        5'd0,  POOL_SMALL}},
    '{KIND_FREE,  8'd0,   6'd17, 5'd1,  1'b1, '{ST_OK,        5'd0,  POOL_LARGE}},
    '{KIND_FREE,  8'd0,   6'd17, 5'd1,  1'b1, '{ST_OK,        5'd0,  POOL_LARGE}},
    '{KIND_FREE,  8'd0,   6'd16, 5'd1,  1'b1, '{ST_OK,        5'd0,  POOL_LARGE}},
    '{KIND_ALLOC, 8'd0,   6'd0,  5'd1,  1'b1, '{ST_OK,        5'd0,  POOL_SMALL}},
    '{KIND_ALLOC, 8'd1,   6'd0,  5'd14, 1'b0, '{ST_OK,        5'd0,  POOL_SMALL}},
    '{KIND_ALLOC, 8'd4,   6'd0,  5'd1,  1'b0, '{ST_OK,        5'd0,  POOL_SMALL}},
    '{KIND_ALLOC, 8'd0,   6'd0,  5'd1,  1'b0, '{ST_OK,        5'd0,  POOL_SMALL}},
    '{KIND_ALLOC, 8'd9,   6'd0,  5'd1,  1'b1, '{ST_NOFIT,     5'd0,  POOL_SMALL}}
  };

  logic [CFG_W-1:0] limit_sets [N_PHASES][2] = '{
    '{8'd1,   8'd255}, '{8'd255, 8'd1},   '{8'd16,  8'd64},  '{8'd1,   8'd1},
    '{8'd64,  8'd16},  '{8'd255, 8'd255}, '{8'd4,   8'd8},   '{8'd100, 8'd200}
  };

  function automatic alloc_result_t allocator_step(input logic kind,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [HANDLE_W-1:0] hdl);
    alloc_result_t r;
    int            p;
    r = '{ST_NOFIT, '0, POOL_SMALL};
    if (kind == KIND_ALLOC) begin
      for (p = 0; p < 2; p++) begin
        if (r.status != ST_OK && size <= size_limit[p] && free_cnt[p] != 0) begin
          r.status    = ST_OK;
          r.handle    = head[p];
          r.pool      = (p == 1) ? POOL_LARGE : POOL_SMALL;
          head[p]     = link_mem[r.handle];
          free_cnt[p] = free_cnt[p] - 1'b1;
        end
      end
    end else if (int'(hdl) >= TOTAL_BLOCKS) begin
      r.status = ST_BADHANDLE;
    end else begin
      p              = int'(hdl) / BLOCKS_PER_POOL;
      link_mem[hdl]  = head[p];
      head[p]        = BLK_W'(hdl);
      if (free_cnt[p] < CNT_W'(BLOCKS_PER_POOL)) free_cnt[p] = free_cnt[p] + 1'b1;
      r.status       = ST_OK;
      r.pool         = (p == 1) ? POOL_LARGE : POOL_SMALL;
    end
    return r;
  endfunction

  task automatic set_limits(input logic [CFG_W-1:0] small_lim,
                            input logic [CFG_W-1:0] large_lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SMALL_BYTES;
    cfg_wdata <= small_lim;
    @(negedge clk);
    cfg_index <= REG_LARGE_BYTES;
    cfg_wdata <= large_lim;
    @(negedge clk);
    cfg_we    <= 1'b0;
    size_limit[0] = small_lim;
    size_limit[1] = large_lim;
    @(negedge clk);
  endtask

  task automatic send_req(input logic kind, input logic [SIZE_W-1:0] size,
                          input logic [HANDLE_W-1:0] hdl, input logic typed,
                          input alloc_result_t typed_res);
    alloc_result_t r;
    int            k;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, hdl, size};
    do @(posedge clk); while (!in_tready);
    r = allocator_step(kind, size, hdl);
    pending_results.push_back(typed ? typed_res : r);
    n_reqs++;
    if (r.status == ST_NOFIT) n_nofit++;
    if (r.status == ST_BADHANDLE) n_badhandle++;
    if (kind == KIND_ALLOC && r.status == ST_OK) begin
      n_ok_alloc++;
      if (r.pool == POOL_LARGE && size <= size_limit[0]) n_fallback++;
      live_blocks.push_back(r.handle);
    end
    if (kind == KIND_FREE && r.status == ST_OK) begin
      n_frees++;
      for (k = 0; k < live_blocks.size(); k++) begin
        if (live_blocks[k] == hdl[BLK_W-1:0]) begin
          live_blocks.delete(k);
          break;
        end
      end
    end
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[1:0], out_tdata[6:2], out_tdata[7]};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    int               i, j, ph, alloc_pct, r, sel, sz;
    logic [HANDLE_W-1:0] h;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_SMALL_BYTES;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser  = KIND_ALLOC;
    in_tdata  = '0;
    gap_pct   = 0;
    stall_pct = 0;
    errors    = 0;
    n_reqs = 0; n_ok_alloc = 0; n_fallback = 0; n_nofit = 0; n_badhandle = 0; n_frees = 0;
    for (i = 0; i < 2; i++) begin
      for (j = 0; j < BLOCKS_PER_POOL; j++) begin
        link_mem[i*BLOCKS_PER_POOL + j] =
          BLK_W'(i*BLOCKS_PER_POOL + ((j + 1) % BLOCKS_PER_POOL));
      end
      head[i]     = BLK_W'(i*BLOCKS_PER_POOL);
      free_cnt[i] = CNT_W'(BLOCKS_PER_POOL);
    end
    size_limit[0] = SMALL_BYTES_RST;
    size_limit[1] = LARGE_BYTES_RST;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < N_DIR; i++) begin
      for (j = 0; j < int'(dir_tab[i].rep); j++) begin
        send_req(dir_tab[i].kind, dir_tab[i].size, dir_tab[i].hdl,
                 dir_tab[i].typed, dir_tab[i].res);
      end
    end
    drain_results();

    for (ph = 0; ph < N_PHASES; ph++) begin
      set_limits(limit_sets[ph][0], limit_sets[ph][1]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      alloc_pct = $urandom_range(75, 35);
      for (i = 0; i < PHASE_REQS; i++) begin
        r = $urandom_range(99);
        if (r < alloc_pct || (r < 92 && live_blocks.size() == 0)) begin
          sel = $urandom_range(3);
          case (sel)
            0: sz = $urandom_range(255);
            1: sz = int'(size_limit[0]) + $urandom_range(2) - 1;
            2: sz = int'(size_limit[1]) + $urandom_range(2) - 1;
            default: sz = $urandom_range(int'(size_limit[1]));
          endcase
          if (sz < 0) sz = 0;
          if (sz > 255) sz = 255;
          send_req(KIND_ALLOC, SIZE_W'(sz), HANDLE_W'($urandom_range(63)), 1'b0, '0);
        end else if (r < 92) begin
          h = HANDLE_W'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
          send_req(KIND_FREE, SIZE_W'($urandom_range(255)), h, 1'b0, '0);
        end else begin
          send_req(KIND_FREE, SIZE_W'($urandom_range(255)),
                   HANDLE_W'($urandom_range(63)), 1'b0, '0);
        end
      end
      drain_results();
    end

    repeat (8) @(negedge clk);
    errors += pending_results.size();
    $display("%0d requests over %0d limit settings: %0d allocs served (%0d by fallback),",
             n_reqs, N_PHASES + 1, n_ok_alloc, n_fallback);
    $display("%0d frees, %0d no-fit, %0d bad handles; %0d mismatches",
             n_frees, n_nofit, n_badhandle, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
